>>> design/bole_pkg.sv
// Shared types and codes for the bounded ordered list engine.
package bole_pkg;

  localparam int unsigned POS_W  = 7;
  localparam int unsigned DATA_W = 32;

  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_INSERT_AT  = 3'd2;
  localparam logic [2:0] OP_POP_FRONT  = 3'd3;
  localparam logic [2:0] OP_POP_BACK   = 3'd4;
  localparam logic [2:0] OP_DELETE_AT  = 3'd5;
  localparam logic [2:0] OP_DUMP       = 3'd6;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_BADPOS = 2'd3;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_DELETE,
    CMD_ROTATE
  } bole_cmd_e;

  typedef struct packed {
    logic [2:0]              op;
    logic [POS_W-1:0]        position;
    logic signed [DATA_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] element;
    logic [POS_W-1:0]         element_index;
    logic [POS_W-1:0]         occupancy;
    logic                     last;
  } out_word_t;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    bole_cmd_e                cmd;
    logic [POS_W-1:0]         slot;   // zero-based target slot
    logic [POS_W-1:0]         count;  // occupancy before the update
    logic signed [DATA_W-1:0] value;  // value to insert
    logic signed [DATA_W-1:0] head;   // front cell, wraps to the back on rotate
  } cell_ctl_t;

endpackage

>>> design/bole_cell.sv
// One storage cell of the list chain.
module bole_cell #(
  parameter int unsigned Index = 0
) (
  input  logic                              clk_i,
  input  bole_pkg::cell_ctl_t               ctl_i,
  input  logic signed [bole_pkg::DATA_W-1:0] left_i,
  input  logic signed [bole_pkg::DATA_W-1:0] right_i,
  output logic signed [bole_pkg::DATA_W-1:0] value_o
);
  import bole_pkg::*;

  localparam logic [POS_W-1:0] Idx  = POS_W'(Index);
  localparam logic [POS_W-1:0] Idx1 = POS_W'(Index + 1);

  logic signed [DATA_W-1:0] value_q, value_d;

  always_comb begin
    value_d = value_q;
    case (ctl_i.cmd)
      CMD_INSERT: begin
        if (Idx == ctl_i.slot) begin
          value_d = ctl_i.value;
        end else if (Idx > ctl_i.slot && Idx <= ctl_i.count) begin
          value_d = left_i;
        end
      end
      CMD_DELETE: begin
        if (Idx >= ctl_i.slot && Idx1 < ctl_i.count) begin
          value_d = right_i;
        end
      end
      CMD_ROTATE: begin
        if (Idx1 < ctl_i.count) begin
          value_d = right_i;
        end else if (Idx1 == ctl_i.count) begin
          value_d = ctl_i.head;
        end
      end
      default: value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

>>> design/bounded_ordered_list_engine.sv
// Bounded ordered list engine: top level with control and the cell chain.
// A change word's status word is registered and shown in the cycle after acceptance.
// Throughput: one change word per cycle while the output is not stalled; a dump stalls input
//   while the chain rotates once, each rotation step giving out the front element as a word.
// Reset: asynchronous, active low; clears occupancy, dump state and output
//   valid. Cell contents are not reset and are only read below occupancy.
module bounded_ordered_list_engine #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bole_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bole_pkg::out_word_t out_word_o
);
  import bole_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [POS_W-1:0] DepthP = POS_W'(DEPTH);

  // Occupancy and dump progress.
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] dump_k_q, dump_k_d;
  logic          dumping_q, dumping_d;

  // Output register.
  logic      out_valid_q, out_valid_d;
  out_word_t out_word_q, out_word_d;

  logic      out_free, accept, emit;
  logic [POS_W-1:0] cnt7, cnt7_inc, cnt7_dec, k7_inc;
  cell_ctl_t ctl;

  logic signed [DATA_W-1:0] cell_val [DEPTH];

  assign cnt7     = POS_W'(count_q);
  assign cnt7_inc = cnt7 + POS_W'(1);
  assign cnt7_dec = cnt7 - POS_W'(1);
  assign k7_inc   = POS_W'(dump_k_q) + POS_W'(1);

  // Output slot can take a new word when empty or being drained now.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = dumping_q || !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    count_d     = count_q;
    dump_k_d    = dump_k_q;
    dumping_d   = dumping_q;
    emit        = 1'b0;
    out_word_d  = '0;
    ctl.cmd     = CMD_HOLD;
    ctl.slot    = '0;
    ctl.count   = cnt7;
    ctl.value   = in_word_i.value;
    ctl.head    = cell_val[0];

    if (accept) begin
      case (in_word_i.op)
        OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT_AT: begin
          emit = 1'b1;
          out_word_d.status = ST_OK;
          if (cnt7 == DepthP) begin
            out_word_d.status = ST_FULL;
          end else if (in_word_i.op == OP_INSERT_AT &&
                       (in_word_i.position == '0 || in_word_i.position > cnt7_inc)) begin
            out_word_d.status = ST_BADPOS;
          end else begin
            ctl.cmd = CMD_INSERT;
            if (in_word_i.op == OP_PUSH_BACK) begin
              ctl.slot = cnt7;
            end else if (in_word_i.op == OP_INSERT_AT) begin
              ctl.slot = in_word_i.position - POS_W'(1);
            end
            count_d = count_q + CW'(1);
          end
        end
        OP_POP_FRONT, OP_POP_BACK, OP_DELETE_AT: begin
          emit = 1'b1;
          out_word_d.status = ST_OK;
          if (count_q == '0) begin
            out_word_d.status = ST_EMPTY;
          end else if (in_word_i.op == OP_DELETE_AT &&
                       (in_word_i.position == '0 || in_word_i.position > cnt7)) begin
            out_word_d.status = ST_BADPOS;
          end else begin
            ctl.cmd = CMD_DELETE;
            if (in_word_i.op == OP_POP_BACK) begin
              ctl.slot = cnt7_dec;
            end else if (in_word_i.op == OP_DELETE_AT) begin
              ctl.slot = in_word_i.position - POS_W'(1);
            end
            count_d = count_q - CW'(1);
          end
        end
        OP_DUMP: begin
          if (count_q == '0) begin
            emit = 1'b1;
            out_word_d.status = ST_EMPTY;
          end else begin
            dumping_d = 1'b1;
            dump_k_d  = '0;
          end
        end
        default: ; // unused opcode: no effect, no word
      endcase
      out_word_d.occupancy = POS_W'(count_d);
      out_word_d.last      = 1'b1;
    end else if (dumping_q && out_free) begin
      // Front cell goes out, chain rotates so the list is whole afterwards.
      emit                     = 1'b1;
      ctl.cmd                  = CMD_ROTATE;
      out_word_d.status        = ST_OK;
      out_word_d.element       = cell_val[0];
      out_word_d.element_index = k7_inc;
      out_word_d.occupancy     = cnt7;
      out_word_d.last          = (k7_inc == cnt7);
      dump_k_d                 = dump_k_q + CW'(1);
      if (k7_inc == cnt7) begin
        dumping_d = 1'b0;
      end
    end
  end

  assign out_valid_d = emit || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      dump_k_q    <= '0;
      dumping_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      dump_k_q    <= dump_k_d;
      dumping_q   <= dumping_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_word_q <= out_word_d;
    end
  end

  // Cell chain, front at index 0.
  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
    logic signed [DATA_W-1:0] left_w, right_w;
    if (gi == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_val[gi-1];
    end
    if (gi == DEPTH - 1) begin : g_end
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_val[gi+1];
    end
    bole_cell #(.Index(gi)) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .left_i  (left_w),
      .right_i (right_w),
      .value_o (cell_val[gi])
    );
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

>>> design/bole_checker.sv
// Port-level checks for the bounded ordered list engine, bound to the top level.
module bole_checker #(
  parameter int unsigned DEPTH = 16
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input bole_pkg::in_word_t  in_word_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input bole_pkg::out_word_t out_word_o
);
  import bole_pkg::*;

  localparam logic [POS_W-1:0] DepthP = POS_W'(DEPTH);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled output word changed");

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_word_o.occupancy <= DepthP)
    else $error("occupancy above depth");

  a_status_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.element_index == '0 |->
      out_word_o.last && out_word_o.element == '0)
    else $error("status word malformed");

  a_elem_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.element_index != '0 |->
      out_word_o.status == ST_OK && out_word_o.element_index <= out_word_o.occupancy)
    else $error("dump word malformed");

  // While a dump word other than the final one is on show, input is held off.
  a_dump_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.last |-> in_stall_o)
    else $error("input taken mid dump");

endmodule

bind bounded_ordered_list_engine bole_checker #(.DEPTH(DEPTH)) u_bole_checker (.*);

>>> bench/tb_bounded_ordered_list_engine.sv
// Self-checking testbench for the bounded ordered list engine: directed and random traffic.
module tb_bounded_ordered_list_engine;
  import bole_pkg::*;

  localparam int unsigned LIST_DEPTH  = 16;
  localparam int unsigned MAX_REPORTS = 10;
  // Opcode with no operation behind it; the block must swallow it silently.
  localparam logic [2:0]  OP_UNUSED   = 3'd7;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_word_t  in_word_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_word_t out_word_o;

  // Shadow of the list contents, front at index 0.
  logic signed [DATA_W-1:0] shadow_list[$];
  // Result words still owed by the block, oldest first.
  out_word_t                owed_words[$];

  int unsigned mismatch_count    = 0;
  int unsigned send_idle_pct     = 0;
  int unsigned recv_stall_pct    = 0;
  int unsigned stall_hold_cycles = 0;
  // Random traffic swings between filling and draining so both ends get hit.
  bit          fill_trend_up     = 1'b1;

  bounded_ordered_list_engine #(
    .DEPTH(LIST_DEPTH)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop, well beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("bounded_ordered_list_engine test failed");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------

  // Result word carrying the occupancy after the shadow has been updated.
  function automatic out_word_t list_result(input logic [1:0] status,
                                            input logic signed [DATA_W-1:0] element,
                                            input int unsigned index,
                                            input bit last_flag);
    out_word_t w;
    w.status        = status;
    w.element       = element;
    w.element_index = POS_W'(index);
    w.occupancy     = POS_W'(shadow_list.size());
    w.last          = last_flag;
    return w;
  endfunction

  // Apply one accepted word to the shadow list and queue what it owes.
  task automatic predict_list_op(input in_word_t w);
    logic [1:0]  status;
    int unsigned fill;
    status = ST_OK;
    fill   = shadow_list.size();
    case (w.op)
      OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT_AT: begin
        // fullness wins over a bad position
        if (fill >= LIST_DEPTH) begin
          status = ST_FULL;
        end else if (w.op == OP_PUSH_FRONT) begin
          shadow_list.push_front(w.value);
        end else if (w.op == OP_PUSH_BACK) begin
          shadow_list.push_back(w.value);
        end else if (w.position < 1 || w.position > fill + 1) begin
          status = ST_BADPOS;
        end else begin
          shadow_list.insert(int'(w.position) - 1, w.value);
        end
      end
      OP_POP_FRONT, OP_POP_BACK, OP_DELETE_AT: begin
        // emptiness wins over a bad position
        if (fill == 0) begin
          status = ST_EMPTY;
        end else if (w.op == OP_POP_FRONT) begin
          void'(shadow_list.pop_front());
        end else if (w.op == OP_POP_BACK) begin
          void'(shadow_list.pop_back());
        end else if (w.position < 1 || w.position > fill) begin
          status = ST_BADPOS;
        end else begin
          shadow_list.delete(int'(w.position) - 1);
        end
      end
      OP_DUMP: begin
        if (fill == 0) begin
          owed_words.push_back(list_result(ST_EMPTY, '0, 0, 1'b1));
        end else begin
          for (int i = 0; i < fill; i++) begin
            owed_words.push_back(list_result(ST_OK, shadow_list[i], i + 1, i + 1 == fill));
          end
        end
        return;
      end
      default: begin
        return;  // unused opcode: no word back
      end
    endcase
    owed_words.push_back(list_result(status, '0, 0, 1'b1));
  endtask

  // ---------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------

  // Offer one word, idling first at random; predict once it is taken.
  // The word is held steady for as long as the block stalls it.
  task automatic send_list_word(input in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_list_op(w);
  endtask

  task automatic send_op(input logic [2:0] op, input int unsigned position,
                         input logic signed [DATA_W-1:0] value);
    in_word_t w;
    w.op       = op;
    w.position = POS_W'(position);
    w.value    = value;
    send_list_word(w);
  endtask

  // Drop valid and hold off until every owed word has come back.
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (owed_words.size() != 0);
  endtask

  function automatic logic signed [DATA_W-1:0] random_value();
    case ($urandom_range(15))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return '0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // Mostly sensible requests with legal positions; a little pure noise.
  function automatic in_word_t random_list_word();
    in_word_t    w;
    int unsigned fill;
    int unsigned pick;
    fill = shadow_list.size();
    if (fill >= LIST_DEPTH) fill_trend_up = 1'b0;
    else if (fill == 0) fill_trend_up = 1'b1;
    w.value    = random_value();
    w.position = POS_W'($urandom);
    pick       = $urandom_range(99);
    if (pick < 4) begin
      w.op = 3'($urandom);
      return w;
    end
    if (pick < 12) begin
      w.op = OP_DUMP;
    end else if (($urandom_range(99) < 75) == fill_trend_up) begin
      case ($urandom_range(2))
        0:       w.op = OP_PUSH_FRONT;
        1:       w.op = OP_PUSH_BACK;
        default: w.op = OP_INSERT_AT;
      endcase
    end else begin
      case ($urandom_range(2))
        0:       w.op = OP_POP_FRONT;
        1:       w.op = OP_POP_BACK;
        default: w.op = OP_DELETE_AT;
      endcase
    end
    // one in ten keeps its raw position so bad positions turn up too
    if ($urandom_range(9) != 0) begin
      if (w.op == OP_INSERT_AT) w.position = POS_W'($urandom_range(fill + 1, 1));
      else if (w.op == OP_DELETE_AT && fill != 0) w.position = POS_W'($urandom_range(fill, 1));
    end
    return w;
  endfunction

  // ---------------------------------------------------------------------
  // Receiver side: checks each taken word, then picks next cycle's stall
  // ---------------------------------------------------------------------

  task automatic check_result(input out_word_t got);
    out_word_t want;
    if (owed_words.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
        $display("unexpected result word: status %0d element %0d index %0d occupancy %0d last %0b",
                 got.status, got.element, got.element_index, got.occupancy, got.last);
      end
      return;
    end
    want = owed_words.pop_front();
    if (got.status !== want.status || got.element !== want.element ||
        got.element_index !== want.element_index || got.occupancy !== want.occupancy ||
        got.last !== want.last) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
        $display("result mismatch: expected status %0d element %0d index %0d occupancy %0d last %0b",
                 want.status, want.element, want.element_index, want.occupancy, want.last);
        $display("                 got      status %0d element %0d index %0d occupancy %0d last %0b",
                 got.status, got.element, got.element_index, got.occupancy, got.last);
      end
    end
  endtask

  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) check_result(out_word_o);
      // a long hold-off, counted down here, takes precedence over random stalls
      if (stall_hold_cycles != 0) begin
        stall_hold_cycles--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Empty-list errors, bad positions at both ends, extreme values,
  // append via count+1, deletes at front, middle and back, unused opcode.
  task automatic test_directed();
    send_op(OP_POP_FRONT, 0, '0);
    send_op(OP_POP_BACK, 0, '0);
    send_op(OP_DELETE_AT, 0, '0);          // empty beats bad position
    send_op(OP_DUMP, 0, '0);               // empty dump: single word
    send_op(OP_INSERT_AT, 0, 32'sd5);
    send_op(OP_INSERT_AT, 2, 32'sd5);
    send_op(OP_INSERT_AT, 1, 32'sh7fff_ffff);
    send_op(OP_PUSH_FRONT, 0, 32'sh8000_0000);
    send_op(OP_PUSH_BACK, 0, -32'sd1);
    send_op(OP_INSERT_AT, 4, '0);          // count+1 appends
    send_op(OP_INSERT_AT, 2, 32'sh5a5a_5a5a);
    send_op(OP_INSERT_AT, 127, 32'sd9);    // all position bits set
    send_op(OP_UNUSED, 127, -32'sd1);      // swallowed, no word back
    send_op(OP_DUMP, 0, '0);
    send_op(OP_DELETE_AT, 0, '0);
    send_op(OP_DELETE_AT, 6, '0);
    send_op(OP_DELETE_AT, 5, '0);          // back
    send_op(OP_DELETE_AT, 1, '0);          // front
    send_op(OP_DELETE_AT, 2, '0);
    send_op(OP_POP_FRONT, 0, '0);
    send_op(OP_POP_BACK, 0, '0);
    send_op(OP_DUMP, 0, '0);
  endtask

  // Fill to capacity, then every add request must report full.
  task automatic test_full_list();
    for (int i = 0; i < LIST_DEPTH; i++) begin
      send_op((i % 2 == 1) ? OP_PUSH_FRONT : OP_PUSH_BACK, 0, random_value());
    end
    send_op(OP_PUSH_FRONT, 0, 32'sd1);
    send_op(OP_PUSH_BACK, 0, 32'sd2);
    send_op(OP_INSERT_AT, 1, 32'sd3);
    send_op(OP_INSERT_AT, 0, 32'sd4);      // full beats bad position
    send_op(OP_DUMP, 0, '0);
    send_op(OP_DELETE_AT, LIST_DEPTH + 1, '0);
  endtask

  // Receiver holds off for a long stretch while dumps of a full or nearly full list
  // keep coming, so the block backs up and stalls its input.
  task automatic test_backpressure();
    wait_for_results();
    stall_hold_cycles = 150;
    send_op(OP_DUMP, 0, '0);
    send_op(OP_POP_BACK, 0, '0);
    send_op(OP_DUMP, 0, '0);
    send_op(OP_PUSH_BACK, 0, 32'sh1234_5678);
    send_op(OP_DUMP, 0, '0);
    send_op(OP_DELETE_AT, 8, '0);
    send_op(OP_DUMP, 0, '0);
    send_op(OP_INSERT_AT, 3, -32'sd77);
    send_op(OP_DUMP, 0, '0);
    wait_for_results();
  endtask

  task automatic test_random_traffic(input int unsigned words, input int unsigned idle_pct,
                                     input int unsigned stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (words) send_list_word(random_list_word());
    wait_for_results();
  endtask

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------

  initial begin
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_word_i  <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_full_list();
    test_backpressure();
    test_random_traffic(30, 0, 0);
    test_random_traffic(30, 83, 0);
    test_random_traffic(30, 0, 83);
    test_random_traffic(30, 26, 26);

    // idle with no traffic to catch any stray word
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0 && owed_words.size() == 0) begin
      $display("bounded_ordered_list_engine test passed");
    end else begin
      $display("bounded_ordered_list_engine test failed");
    end
    $finish;
  end

endmodule

>>> files.f
design/bole_pkg.sv
design/bole_cell.sv
design/bounded_ordered_list_engine.sv
design/bole_checker.sv
bench/tb_bounded_ordered_list_engine.sv
